[rtl/core/tmb_pkg.sv]
package tmb_pkg;

  localparam int TIME_BITS  = 48;
  localparam int IVAL_BITS  = 32;
  localparam int DELAY_BITS = 31;

  localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

  // command codes (s_tuser)
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_STOP    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // result kinds (m_tuser)
  localparam logic KIND_FIRE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef logic [TIME_BITS-1:0] tstamp_t;
  typedef logic [IVAL_BITS-1:0] ival_t;

  typedef struct packed {
    logic load_in;      // capture input beat, restart scan
    logic exec;         // apply start / stop
    logic rd_en;        // read slot memories at scan index
    logic fold_old;     // fold stored deadline into earliest
    logic per_calc;     // register both candidate deadlines
    logic per_wr;       // write back periodic deadline and fold it
    logic oneshot_clr;  // deactivate slot at scan index
    logic idx_inc;
    logic out_fire;
    logic out_sum;
  } tmb_cmd_t;

  typedef struct packed {
    logic due;
    logic periodic;
    logic idx_last;
    logic out_free;
  } tmb_stat_t;

  function automatic tstamp_t sat_add(tstamp_t a, ival_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {{(TIME_BITS + 1 - IVAL_BITS){1'b0}}, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

endpackage

[rtl/core/tmb_datapath.sv]
module tmb_datapath import tmb_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  tmb_cmd_t   cmd,
  output tmb_stat_t  stat,
  input  logic [1:0] in_command,
  input  logic [3:0] in_slot,
  input  ival_t      in_interval,
  input  logic       in_recurring,
  input  tstamp_t    in_now,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [39:0] m_tdata,  // fired_slot[3:0], armed[4], delay_ms[35:5], zero[39:36]
  output logic       m_tuser,   // kind
  output logic       m_tlast
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // captured command
  logic [1:0] cmd_q;
  logic [3:0] slot_q;
  ival_t      ival_q;
  logic       rec_q;
  tstamp_t    now_q;

  logic [SW-1:0]        idx;
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] periodic;

  tstamp_t dl_mem [NUM_SLOTS];
  ival_t   iv_mem [NUM_SLOTS];
  tstamp_t dl_q;
  ival_t   iv_q;

  tstamp_t cand;
  tstamp_t alt;
  tstamp_t per_new;

  logic    armed_acc;
  tstamp_t earliest;

  logic            out_valid;
  logic            out_kind;
  logic [3:0]      out_slot;
  logic            out_armed;
  logic [DELAY_BITS-1:0] out_delay;
  logic            out_last;

  logic [8:0]    slot_ext;
  logic [8:0]    idx_ext;
  logic          slot_ok;
  logic [SW-1:0] slot_addr;
  logic          start_wr;
  logic          stop_wr;
  logic          dl_we;
  logic [SW-1:0] dl_waddr;
  tstamp_t       dl_wdata;
  logic          cur_active;
  logic          fold_en;
  tstamp_t       fold_val;
  logic [TIME_BITS:0]    diff;
  logic                  le_now;
  logic                  big;
  logic [DELAY_BITS-1:0] sum_delay;

  assign slot_ext  = {5'd0, slot_q};
  assign idx_ext   = {{(9 - SW){1'b0}}, idx};
  assign slot_ok   = slot_ext < 9'(NUM_SLOTS);
  assign slot_addr = slot_ext[SW-1:0];
  assign start_wr  = cmd.exec && (cmd_q == CMD_START) && slot_ok;
  assign stop_wr   = cmd.exec && (cmd_q == CMD_STOP) && slot_ok;

  assign dl_we    = start_wr || cmd.per_wr;
  assign dl_waddr = cmd.per_wr ? idx : slot_addr;
  assign dl_wdata = cmd.per_wr ? per_new : sat_add(now_q, ival_q);

  assign cur_active = active[idx];
  // catch-up: if one interval step is still not in the future, restart from now
  assign per_new    = (cand <= now_q) ? alt : cand;
  assign fold_en    = cmd.per_wr || (cmd.fold_old && cur_active);
  assign fold_val   = cmd.per_wr ? per_new : dl_q;

  assign stat.due      = cur_active && (dl_q <= now_q) && (cmd_q == CMD_ADVANCE);
  assign stat.periodic = periodic[idx];
  assign stat.idx_last = idx == SW'(NUM_SLOTS - 1);
  assign stat.out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q  <= in_command;
      slot_q <= in_slot;
      ival_q <= in_interval;
      rec_q  <= in_recurring;
      now_q  <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load_in) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      periodic <= '0;
    end else begin
      if (start_wr) begin
        active[slot_addr]   <= 1'b1;
        periodic[slot_addr] <= rec_q;
      end
      if (stop_wr) begin
        active[slot_addr] <= 1'b0;
      end
      if (cmd.oneshot_clr) begin
        active[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_wr) begin
      iv_mem[slot_addr] <= ival_q;
    end
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    if (cmd.rd_en) begin
      dl_q <= dl_mem[idx];
      iv_q <= iv_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.per_calc) begin
      cand <= sat_add(dl_q, iv_q);
      alt  <= sat_add(now_q, iv_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_acc <= 1'b0;
    end else if (cmd.load_in) begin
      armed_acc <= 1'b0;
    end else if (fold_en) begin
      armed_acc <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_en && (!armed_acc || fold_val < earliest)) begin
      earliest <= fold_val;
    end
  end

  // summary delay
  assign diff   = {1'b0, earliest} - {1'b0, now_q};
  assign le_now = earliest <= now_q;
  assign big    = |diff[TIME_BITS-1:DELAY_BITS];

  always_comb begin
    if (!armed_acc) begin
      sum_delay = '0;
    end else if (le_now) begin
      sum_delay = DELAY_BITS'(1);
    end else if (big) begin
      sum_delay = DELAY_MAX;
    end else begin
      sum_delay = diff[DELAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_fire || cmd.out_sum) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_kind  <= KIND_FIRE;
      out_slot  <= idx_ext[3:0];
      out_armed <= 1'b0;
      out_delay <= '0;
      out_last  <= 1'b0;
    end else if (cmd.out_sum) begin
      out_kind  <= KIND_SUMMARY;
      out_slot  <= 4'd0;
      out_armed <= armed_acc;
      out_delay <= sum_delay;
      out_last  <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_delay, out_armed, out_slot};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  a_last_is_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == out_kind))
    else $error("last flag does not match result kind");

  a_disarmed_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_SUMMARY && !out_armed) |-> (out_delay == '0))
    else $error("disarmed summary with nonzero delay");

  a_armed_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_SUMMARY && out_armed) |-> (out_delay != '0))
    else $error("armed summary with zero delay");

  a_fire_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_FIRE) |-> (!out_armed && out_delay == '0))
    else $error("fire beat carries summary fields");

endmodule

[rtl/core/tmb_ctrl.sv]
module tmb_ctrl import tmb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  tmb_stat_t stat,
  output tmb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    RD,
    EVAL,
    PER,
    FIRE,
    SUM
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = EXEC;
        end
      end
      EXEC: begin
        cmd.exec   = 1'b1;
        state_next = RD;
      end
      RD: begin
        cmd.rd_en  = 1'b1;
        state_next = EVAL;
      end
      EVAL: begin
        if (stat.due) begin
          cmd.per_calc = 1'b1;
          if (stat.periodic) begin
            state_next = PER;
          end else begin
            cmd.oneshot_clr = 1'b1;
            state_next      = FIRE;
          end
        end else begin
          cmd.fold_old = 1'b1;
          if (stat.idx_last) begin
            state_next = SUM;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = RD;
          end
        end
      end
      PER: begin
        cmd.per_wr = 1'b1;
        state_next = FIRE;
      end
      FIRE: begin
        if (stat.out_free) begin
          cmd.out_fire = 1'b1;
          if (stat.idx_last) begin
            state_next = SUM;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = RD;
          end
        end
      end
      SUM: begin
        if (stat.out_free) begin
          cmd.out_sum = 1'b1;
          state_next  = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  a_fire_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_fire || cmd.out_sum) |-> stat.out_free)
    else $error("result loaded into a full output register");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == EXEC))
    else $error("accepted beat not executed");

  a_periodic_write: assert property (@(posedge clk) disable iff (rst)
    cmd.per_wr |-> $past(cmd.per_calc))
    else $error("periodic write-back without candidate computation");

endmodule

[rtl/core/multi_slot_timer_bank.sv]
// Timer bank: one command beat in, zero or more fire beats then one summary beat out.
// Flow: capture the beat and execute start/stop, then scan each slot in turn (one memory
// read, one evaluate); a fired one-shot adds the FIRE state, a fired periodic slot adds PER
// and FIRE, and the SUM state loads the summary. A new command is accepted only in IDLE,
// after the whole scan; output stalls hold the FIRE and SUM states.
// Reset (rst, sync, active high) clears all active/periodic bits and the output valid.
module multi_slot_timer_bank import tmb_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // slot[3:0], interval[35:4], recurring[36],
                                // now_ms[84:37], zero[87:85]
  input  logic [1:0]  s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // fired_slot[3:0], armed[4], delay_ms[35:5], zero[39:36]
  output logic        m_tuser,  // kind
  output logic        m_tlast
);

  tmb_cmd_t  cmd;
  tmb_stat_t stat;

  tmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tmb_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (s_tuser),
    .in_slot      (s_tdata[3:0]),
    .in_interval  (s_tdata[35:4]),
    .in_recurring (s_tdata[36]),
    .in_now       (s_tdata[84:37]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

endmodule

[verif/testbench.sv]
module testbench;
  import tmb_pkg::*;

  localparam int NUM_TIMERS  = 16;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 45;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] idx;
    ival_t      ival;
    logic       rec;
    tstamp_t    now;
  } timer_cmd_t;

  typedef struct packed {
    logic                  kind;
    logic [3:0]            slot;
    logic                  armed;
    logic [DELAY_BITS-1:0] delay;
    logic                  last;
  } timer_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;   // slot, interval, recurring, now_ms, zero pad
  logic [1:0]  s_tuser = CMD_ADVANCE;  // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // fired_slot, armed, delay_ms, zero pad
  logic        m_tuser;        // kind
  logic        m_tlast;

  timer_cmd_t  pending_cmds[$];
  timer_beat_t expected_beats[$];

  // shadow copy of the timer bank
  logic    timer_on[NUM_TIMERS];
  logic    timer_repeat[NUM_TIMERS];
  ival_t   timer_period[NUM_TIMERS];
  tstamp_t timer_due[NUM_TIMERS];

  int          mismatches = 0;
  int          n_queued = 0;
  int          idle_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned hold_cnt = 0;
  int          mode_cnt = 0;
  logic        no_idle = 1'b0;
  timer_cmd_t  next_cmd;

  multi_slot_timer_bank #(.NUM_SLOTS(NUM_TIMERS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  function automatic tstamp_t deadline_add(tstamp_t base, ival_t step);
    logic [TIME_BITS:0] total;
    total = {1'b0, base} + {{(TIME_BITS + 1 - IVAL_BITS){1'b0}}, step};
    if (total > {1'b0, TIME_MAX})
      return TIME_MAX;
    return total[TIME_BITS-1:0];
  endfunction

  function automatic void push_beat(logic kind, logic [3:0] slot, logic armed,
                                    logic [DELAY_BITS-1:0] delay, logic last);
    timer_beat_t b;
    b.kind  = kind;
    b.slot  = slot;
    b.armed = armed;
    b.delay = delay;
    b.last  = last;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // Updates the shadow bank for one command and queues the beats it yields.
  function automatic void apply_command(logic [1:0] op, logic [3:0] idx, ival_t ival,
                                        logic rec, tstamp_t now);
    tstamp_t               nxt;
    tstamp_t               soonest;
    tstamp_t               diff;
    logic                  any;
    logic [DELAY_BITS-1:0] delay;
    any = 1'b0;
    soonest = '0;
    delay = '0;
    case (op)
      CMD_START: begin
        timer_period[idx] = ival;
        timer_repeat[idx] = rec;
        timer_due[idx]    = deadline_add(now, ival);
        timer_on[idx]     = 1'b1;
      end
      CMD_STOP: begin
        timer_on[idx] = 1'b0;
      end
      CMD_ADVANCE: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (timer_on[i] && timer_due[i] <= now) begin
            if (timer_repeat[i]) begin
              nxt = deadline_add(timer_due[i], timer_period[i]);
              // long gap: skip ahead instead of firing a backlog
              if (nxt <= now)
                nxt = deadline_add(now, timer_period[i]);
              timer_due[i] = nxt;
            end else begin
              timer_on[i] = 1'b0;
            end
            push_beat(KIND_FIRE, 4'(i), 1'b0, '0, 1'b0);
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (timer_on[i]) begin
        if (!any || timer_due[i] < soonest)
          soonest = timer_due[i];
        any = 1'b1;
      end
    end
    if (any) begin
      if (soonest <= now) begin
        delay = DELAY_BITS'(1);
      end else begin
        diff = soonest - now;
        delay = (diff > {{(TIME_BITS - DELAY_BITS){1'b0}}, DELAY_MAX}) ?
                DELAY_MAX : diff[DELAY_BITS-1:0];
      end
    end
    push_beat(KIND_SUMMARY, 4'd0, any, delay, 1'b1);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic tstamp_t rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_BITS-1:0];
  endfunction

  task automatic queue_cmd(logic [1:0] op, logic [3:0] idx, ival_t ival, logic rec,
                           tstamp_t now);
    timer_cmd_t c;
    c.op   = op;
    c.idx  = idx;
    c.ival = ival;
    c.rec  = rec;
    c.now  = now;
    pending_cmds.insert(pending_cmds.size(), c);
    n_queued++;
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_beat();
    timer_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
                                m_tdata, m_tuser, m_tlast));
      return;
    end
    want = expected_beats.pop_front();
    if (m_tuser !== want.kind)
      report_mismatch($sformatf("kind %b, want %b", m_tuser, want.kind));
    if (m_tdata[3:0] !== want.slot)
      report_mismatch($sformatf("fired_slot %0d, want %0d", m_tdata[3:0], want.slot));
    if (m_tdata[4] !== want.armed)
      report_mismatch($sformatf("armed %b, want %b", m_tdata[4], want.armed));
    if (m_tdata[35:5] !== want.delay)
      report_mismatch($sformatf("delay_ms %0d, want %0d", m_tdata[35:5], want.delay));
    if (m_tlast !== want.last)
      report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (s_tvalid && s_tready)
        apply_command(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[36], s_tdata[84:37]);
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          s_tdata  <= {3'b000, next_cmd.now, next_cmd.rec, next_cmd.ival, next_cmd.idx};
          s_tuser  <= next_cmd.op;
          s_tvalid <= 1'b1;
          send_wait = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and output backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (m_tvalid && m_tready)
        check_beat();
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        hold_cnt = pick_gap();
      end
    end
  end

  // stretches where neither side idles
  always @(posedge clk) begin
    mode_cnt <= (mode_cnt == 63) ? 0 : mode_cnt + 1;
    if (mode_cnt == 63)
      no_idle <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    tstamp_t clock_ms;
    int      r;
    int      k;
    int      base;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_on[i]     = 1'b0;
      timer_repeat[i] = 1'b0;
      timer_period[i] = '0;
      timer_due[i]    = '0;
    end

    // directed: empty bank, zero interval, huge interval, restart, top of time range
    queue_cmd(CMD_ADVANCE, 4'd9, $urandom, 1'b1, '0);
    queue_cmd(CMD_START, 4'd0, 32'd10, 1'b0, 48'd100);
    queue_cmd(CMD_START, 4'd15, 32'd0, 1'b1, 48'd100);
    queue_cmd(CMD_START, 4'd7, 32'hFFFF_FFFF, 1'b1, 48'd100);
    queue_cmd(CMD_ADVANCE, 4'd0, $urandom, 1'b0, 48'd105);
    queue_cmd(CMD_ADVANCE, 4'd0, $urandom, 1'b1, 48'd110);
    queue_cmd(CMD_STOP, 4'd15, $urandom, 1'b0, 48'd111);
    queue_cmd(CMD_STOP, 4'd3, $urandom, 1'b1, 48'd111);
    queue_cmd(CMD_START, 4'd7, 32'd5, 1'b1, 48'd200);
    queue_cmd(CMD_ADVANCE, 4'd0, $urandom, 1'b0, 48'd1000);
    queue_cmd(CMD_START, 4'd1, 32'hFFFF_FFFF, 1'b0, TIME_MAX - 48'd5);
    queue_cmd(2'd3, 4'd7, $urandom, 1'b1, TIME_MAX - 48'd5);
    queue_cmd(CMD_START, 4'd2, 32'd1, 1'b1, TIME_MAX - 48'd1);
    queue_cmd(CMD_ADVANCE, 4'd0, $urandom, 1'b0, TIME_MAX);
    queue_cmd(CMD_ADVANCE, 4'd0, $urandom, 1'b1, TIME_MAX);
    queue_cmd(CMD_STOP, 4'd2, $urandom, 1'b0, TIME_MAX);
    queue_cmd(CMD_STOP, 4'd7, $urandom, 1'b1, 48'd5);
    queue_cmd(CMD_START, 4'd4, 32'd0, 1'b0, 48'd0);
    queue_cmd(CMD_ADVANCE, 4'd0, $urandom, 1'b0, 48'd0);

    clock_ms = 48'd1000;
    while (n_queued < 360) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        queue_cmd(CMD_START, 4'($urandom_range(0, 15)),
                  ($urandom_range(0, 9) == 0) ? ival_t'($urandom) : ival_t'($urandom_range(0, 40)),
                  1'($urandom_range(0, 1)), clock_ms);
        clock_ms += tstamp_t'($urandom_range(0, 15));
      end else if (r < 60) begin
        clock_ms += tstamp_t'($urandom_range(0, 40));
        queue_cmd(CMD_ADVANCE, 4'($urandom), $urandom, 1'($urandom), clock_ms);
      end else if (r < 70) begin
        queue_cmd(CMD_STOP, 4'($urandom_range(0, 15)), $urandom, 1'($urandom), clock_ms);
      end else if (r < 76) begin
        // fill a run of slots, then fire them together
        k = $urandom_range(4, NUM_TIMERS);
        base = $urandom_range(0, NUM_TIMERS - 1);
        for (int j = 0; j < k; j++)
          queue_cmd(CMD_START, 4'((base + j) % NUM_TIMERS), ival_t'($urandom_range(0, 5)),
                    1'($urandom_range(0, 1)), clock_ms);
        clock_ms += 48'd10;
        queue_cmd(CMD_ADVANCE, 4'($urandom), $urandom, 1'($urandom), clock_ms);
      end else if (r < 81) begin
        clock_ms += tstamp_t'($urandom_range(100, 100000));
        queue_cmd(CMD_ADVANCE, 4'($urandom), $urandom, 1'($urandom), clock_ms);
      end else if (r < 85) begin
        clock_ms = TIME_MAX - tstamp_t'($urandom_range(0, 200));
        queue_cmd(CMD_ADVANCE, 4'($urandom), $urandom, 1'($urandom), clock_ms);
      end else if (r < 90) begin
        clock_ms = ($urandom_range(0, 1) == 0) ? tstamp_t'($urandom_range(0, 1000)) : rand_time();
        queue_cmd(CMD_ADVANCE, 4'($urandom), $urandom, 1'($urandom), clock_ms);
      end else begin
        queue_cmd(2'($urandom_range(0, 3)), 4'($urandom), $urandom, 1'($urandom), rand_time());
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
